// ===== rtl/tpse_pkg.sv =====
// shared constants, types and the exp table for the two-part se kernel entry
package tpse_pkg;

	localparam int DIMS = 3;
	localparam int MAXD = 3;
	localparam int NSTG = 9;

	localparam int CW  = 24;
	localparam int DW  = CW + 1;
	localparam int SQW = 32;
	localparam int TW  = SQW + CW - 16;
	localparam int SW  = TW + 2;
	localparam int XW  = SW + 2;
	localparam int OW  = 32;

	localparam logic [2:0] REG_WM0 = 3'd0;
	localparam logic [2:0] REG_WM1 = 3'd1;
	localparam logic [2:0] REG_WM2 = 3'd2;
	localparam logic [2:0] REG_WT0 = 3'd3;
	localparam logic [2:0] REG_WT1 = 3'd4;
	localparam logic [2:0] REG_WT2 = 3'd5;
	localparam logic [2:0] REG_LM  = 3'd6;
	localparam logic [2:0] REG_LT  = 3'd7;

	localparam logic [CW-1:0] WEIGHT_RST = 24'd65536;
	localparam int EXP_LIMIT = 786432;
	localparam logic signed [17:0] LOG2E_Q16 = 18'sd94548;
	localparam logic signed [39:0] EXP_BIAS = 40'sd137438953472;

	typedef logic [CW-1:0] weight_t;
	typedef logic [TW-1:0] term_t;
	typedef logic [SW-1:0] dist_t;

	// 2^(i/16) in q.16
	function automatic logic [17:0] pow2_tab(input logic [4:0] i);
		logic [17:0] v;
		case (i)
			5'd0: v = 18'd65536;
			5'd1: v = 18'd68438;
			5'd2: v = 18'd71468;
			5'd3: v = 18'd74632;
			5'd4: v = 18'd77936;
			5'd5: v = 18'd81386;
			5'd6: v = 18'd84990;
			5'd7: v = 18'd88752;
			5'd8: v = 18'd92682;
			5'd9: v = 18'd96785;
			5'd10: v = 18'd101070;
			5'd11: v = 18'd105545;
			5'd12: v = 18'd110218;
			5'd13: v = 18'd115098;
			5'd14: v = 18'd120194;
			5'd15: v = 18'd125515;
			default: v = 18'd131072;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/tpse_lane.sv =====
// one dimension lane: difference, square and the two weighted terms
module tpse_lane import tpse_pkg::*; (
	input  logic                 clk,
	input  logic [2:0]           en,
	input  logic signed [CW-1:0] row,
	input  logic signed [CW-1:0] col,
	input  weight_t              w_main,
	input  weight_t              w_treat,
	output term_t                term_main,
	output term_t                term_treat
);

	logic signed [DW-1:0] diff_s1;
	logic [SQW-1:0]       sq_s2;
	term_t                tm_s3, tt_s3;
	logic signed [2*DW-1:0] sq_full;
	logic [SQW+CW-1:0]    pm, pt;

	assign sq_full = diff_s1 * diff_s1;
	assign pm = sq_s2 * w_main;
	assign pt = sq_s2 * w_treat;

	always_ff @(posedge clk) begin
		if (en[0]) diff_s1 <= DW'(row) - DW'(col);
		if (en[1]) sq_s2 <= sq_full[SQW+15:16];
		if (en[2]) begin
			tm_s3 <= pm[SQW+CW-1:16];
			tt_s3 <= pt[SQW+CW-1:16];
		end
	end

	assign term_main = tm_s3;
	assign term_treat = tt_s3;

endmodule

// ===== rtl/tpse_exp.sv =====
// pipelined exp of (lambda - distance): clamp, log2e scale, table interpolation, shift
module tpse_exp import tpse_pkg::*; (
	input  logic                 clk,
	input  logic [3:0]           en,
	input  logic signed [CW-1:0] lambda,
	input  dist_t                distance,
	output logic [OW-1:0]        res
);

	logic signed [XW-1:0] x;
	logic signed [20:0] x_s5;
	logic sat_s5, zero_s5, sat_s6, zero_s6, sat_s7, zero_s7;
	logic signed [39:0] prod, e_full;
	logic [5:0]  n_s6, n_s7;
	logic [15:0] f_s6;
	logic [17:0] m_s7, t_lo, t_hi, m;
	logic [24:0] interp;
	logic [34:0] wide;
	logic [17:0] narrow;
	logic [OW-1:0] res_s8, res_d;

	assign x = XW'(lambda) - $signed({2'b00, distance});
	assign prod = x_s5 * LOG2E_Q16;
	assign e_full = prod + EXP_BIAS;

	assign t_lo = pow2_tab({1'b0, f_s6[15:12]});
	assign t_hi = pow2_tab(5'({1'b0, f_s6[15:12]}) + 5'd1);
	assign interp = (t_hi - t_lo) * f_s6[11:0];
	assign m = t_lo + 18'(interp[24:12]);

	assign wide = {17'd0, m_s7} << (n_s7 - 6'd32);
	assign narrow = m_s7 >> (6'd32 - n_s7);

	always_comb begin
		if (sat_s7) res_d = '1;
		else if (zero_s7) res_d = '0;
		else if (n_s7 >= 6'd32) res_d = (wide[34:32] != 3'd0) ? '1 : wide[31:0];
		else res_d = OW'(narrow);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sat_s5 <= x > XW'(EXP_LIMIT);
			zero_s5 <= x < -XW'(EXP_LIMIT);
			x_s5 <= x[20:0];
		end
		if (en[1]) begin
			sat_s6 <= sat_s5;
			zero_s6 <= zero_s5;
			n_s6 <= e_full[37:32];
			f_s6 <= e_full[31:16];
		end
		if (en[2]) begin
			sat_s7 <= sat_s6;
			zero_s7 <= zero_s6;
			n_s7 <= n_s6;
			m_s7 <= m;
		end
		if (en[3]) res_s8 <= res_d;
	end

	assign res = res_s8;

endmodule

// ===== rtl/two_part_se_kernel_entry.sv =====
// top level: config registers, dimension lanes, distance merge, two exp units, output
//
// One kernel matrix entry per transaction. The input channel (in_valid/in_ready)
// carries a pair of points and their treatment masks; the output channel
// (out_valid/out_ready) returns kernel_total, kernel_main and kernel_treat.
// The entry passes through 3 lane stages
// (difference, square, weighting), 1 merge stage summing the lanes, 4 exp
// stages and 1 output stage adding the two parts with saturation.
// Throughput is one entry per cycle while out_ready is high; each stage holds
// its own valid bit and refills as soon as the stage after it moves, so bubbles
// are squeezed out. When the receiver stalls, results back up stage by stage and
// in_ready drops only once every stage holds an entry.
// Configuration uses cfg_we/cfg_index/cfg_wdata, one register per write, and
// must be written while no entry is in flight.
// Reset (arst_n low) empties the pipeline, sets all weights to 1.0 and both
// lambdas to 0.
module two_part_se_kernel_entry import tpse_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [23:0]   cfg_wdata,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic signed [23:0] row_coord_d0,
	input  logic signed [23:0] row_coord_d1,
	input  logic signed [23:0] row_coord_d2,
	input  logic signed [23:0] col_coord_d0,
	input  logic signed [23:0] col_coord_d1,
	input  logic signed [23:0] col_coord_d2,
	input  logic          row_treated,
	input  logic          col_treated,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   kernel_total,
	output logic [31:0]   kernel_main,
	output logic [31:0]   kernel_treat
);

	weight_t wm_q [MAXD];
	weight_t wt_q [MAXD];
	logic signed [CW-1:0] lm_q, lt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < MAXD; d++) begin
				wm_q[d] <= WEIGHT_RST;
				wt_q[d] <= WEIGHT_RST;
			end
			lm_q <= '0;
			lt_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WM0: wm_q[0] <= cfg_wdata;
				REG_WM1: wm_q[1] <= cfg_wdata;
				REG_WM2: wm_q[2] <= cfg_wdata;
				REG_WT0: wt_q[0] <= cfg_wdata;
				REG_WT1: wt_q[1] <= cfg_wdata;
				REG_WT2: wt_q[2] <= cfg_wdata;
				REG_LM:  lm_q <= cfg_wdata;
				REG_LT:  lt_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// stage valids and enables
	logic [NSTG:1] v_q;
	logic [NSTG:1] en;
	logic [NSTG:0] v_in;

	assign v_in = {v_q, in_valid};
	always_comb begin
		en[NSTG] = !v_q[NSTG] || out_ready;
		for (int k = NSTG - 1; k >= 1; k--) en[k] = !v_q[k] || en[k+1];
	end
	assign in_ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else begin
			for (int k = 1; k <= NSTG; k++) if (en[k]) v_q[k] <= v_in[k-1];
		end
	end

	logic signed [CW-1:0] row [MAXD];
	logic signed [CW-1:0] col [MAXD];
	assign row[0] = row_coord_d0;
	assign row[1] = row_coord_d1;
	assign row[2] = row_coord_d2;
	assign col[0] = col_coord_d0;
	assign col[1] = col_coord_d1;
	assign col[2] = col_coord_d2;

	term_t tm [DIMS];
	term_t tt [DIMS];

	for (genvar d = 0; d < DIMS; d++) begin : g_lane
		tpse_lane u_lane (
			.clk        (clk),
			.en         (en[3:1]),
			.row        (row[d]),
			.col        (col[d]),
			.w_main     (wm_q[d]),
			.w_treat    (wt_q[d]),
			.term_main  (tm[d]),
			.term_treat (tt[d])
		);
	end

	// merge the lanes into two distances
	dist_t dm_sum, dt_sum, dm_s4, dt_s4;
	always_comb begin
		dm_sum = '0;
		dt_sum = '0;
		for (int d = 0; d < DIMS; d++) begin
			dm_sum = dm_sum + SW'(tm[d]);
			dt_sum = dt_sum + SW'(tt[d]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			dm_s4 <= dm_sum;
			dt_s4 <= dt_sum;
		end
	end

	logic [OW-1:0] em, et;

	tpse_exp u_exp_main (
		.clk      (clk),
		.en       (en[8:5]),
		.lambda   (lm_q),
		.distance (dm_s4),
		.res      (em)
	);

	tpse_exp u_exp_treat (
		.clk      (clk),
		.en       (en[8:5]),
		.lambda   (lt_q),
		.distance (dt_s4),
		.res      (et)
	);

	// treatment mask follows the entry down the pipe
	logic [NSTG-1:1] both_q;
	always_ff @(posedge clk) begin
		if (en[1]) both_q[1] <= row_treated & col_treated;
		for (int k = 2; k < NSTG; k++) if (en[k]) both_q[k] <= both_q[k-1];
	end

	logic [OW-1:0] tr_m;
	logic [OW:0]   sum;
	logic [OW-1:0] tot_s9, km_s9, kt_s9;

	assign tr_m = both_q[NSTG-1] ? et : '0;
	assign sum = {1'b0, em} + {1'b0, tr_m};

	always_ff @(posedge clk) begin
		if (en[NSTG]) begin
			tot_s9 <= sum[OW] ? '1 : sum[OW-1:0];
			km_s9 <= em;
			kt_s9 <= tr_m;
		end
	end

	assign out_valid = v_q[NSTG];
	assign kernel_total = tot_s9;
	assign kernel_main = km_s9;
	assign kernel_treat = kt_s9;

	a_total_ge_main: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kernel_total >= kernel_main) else $error("total below main part");
	a_total_ge_treat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kernel_total >= kernel_treat) else $error("total below treat part");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready && v_q[1]) else $error("input stalled with room");

endmodule

// ===== tb/tb.sv =====
// testbench for the two-part se kernel entry: random streams checked against a local predictor
`timescale 1ns / 1ps

import tpse_pkg::*;

typedef struct {
	logic [31:0] total;
	logic [31:0] kmain;
	logic [31:0] ktreat;
} kentry_t;

class kernel_scoreboard;
	logic [23:0] wmain [3];
	logic [23:0] wtreat [3];
	logic signed [23:0] lam_main;
	logic signed [23:0] lam_treat;
	kentry_t pending [$];
	int mismatches;

	function void reset_regs();
		for (int d = 0; d < 3; d++) begin
			wmain[d] = WEIGHT_RST;
			wtreat[d] = WEIGHT_RST;
		end
		lam_main = '0;
		lam_treat = '0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [23:0] v);
		case (idx)
			REG_WM0: wmain[0] = v;
			REG_WM1: wmain[1] = v;
			REG_WM2: wmain[2] = v;
			REG_WT0: wtreat[0] = v;
			REG_WT1: wtreat[1] = v;
			REG_WT2: wtreat[2] = v;
			REG_LM:  lam_main = v;
			REG_LT:  lam_treat = v;
			default: ;
		endcase
	endfunction

	function logic [63:0] pow2_q16(int i);
		logic [63:0] t [17] = '{65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752,
			92682, 96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072};
		return t[i];
	endfunction

	function logic [31:0] exp_fixed(longint x);
		longint tprod;
		logic [63:0] e, m, r;
		int n, i, fr;
		if (x > 786432) return 32'hFFFF_FFFF;
		if (x < -786432) return 0;
		tprod = x * 94548;
		e = 64'((tprod + (longint'(32) << 32)) >>> 16);
		n = int'(e[31:16]);
		i = int'(e[15:12]);
		fr = int'(e[11:0]);
		m = pow2_q16(i) + (((pow2_q16(i + 1) - pow2_q16(i)) * 64'(fr)) >> 12);
		r = (n >= 32) ? (m << (n - 32)) : (m >> (32 - n));
		if (r > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
		return r[31:0];
	endfunction

	function void note_pair(logic signed [23:0] rc [3], logic signed [23:0] cc [3],
			logic rt, logic ct);
		longint dm, dt, diff, sq;
		logic [63:0] sum;
		kentry_t k;
		dm = 0;
		dt = 0;
		for (int d = 0; d < DIMS; d++) begin
			diff = longint'(rc[d]) - longint'(cc[d]);
			sq = (diff * diff) >>> 16;
			dm += (sq * longint'(wmain[d])) >>> 16;
			dt += (sq * longint'(wtreat[d])) >>> 16;
		end
		k.kmain = exp_fixed(longint'(lam_main) - dm);
		k.ktreat = (rt && ct) ? exp_fixed(longint'(lam_treat) - dt) : 32'd0;
		sum = 64'(k.kmain) + 64'(k.ktreat);
		k.total = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
		pending.push_back(k);
	endfunction

	function void check_entry(logic [31:0] tot, logic [31:0] km, logic [31:0] kt);
		kentry_t k;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result %h %h %h", tot, km, kt);
			return;
		end
		k = pending.pop_front();
		if (k.total !== tot || k.kmain !== km || k.ktreat !== kt) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp total %h main %h treat %h, got %h %h %h",
					k.total, k.kmain, k.ktreat, tot, km, kt);
		end
	endfunction
endclass

module tb;
	logic clk, arst_n, cfg_we;
	logic [2:0] cfg_index;
	logic [23:0] cfg_wdata;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [23:0] row_coord_d0, row_coord_d1, row_coord_d2;
	logic signed [23:0] col_coord_d0, col_coord_d1, col_coord_d2;
	logic row_treated, col_treated;
	logic [31:0] kernel_total, kernel_main, kernel_treat;

	kernel_scoreboard sb;
	int idle_cycles;

	two_part_se_kernel_entry uut (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic int gap_len();
		int p = $urandom_range(99);
		if (p < 40) return 0;
		if (p < 90) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	function automatic logic [23:0] rand_coord(int mode);
		case (mode)
			0: return 24'($urandom);
			1: return 24'($urandom_range(131072));
			2: return 24'sh7FFFFF;
			3: return 24'sh800000;
			default: return 24'($urandom_range(255) - 128);
		endcase
	endfunction

	// valid stays high after a transaction until the next gap or a drain
	task automatic send_pair(logic signed [23:0] rc [3], logic signed [23:0] cc [3],
			logic rt, logic ct, bit with_gap);
		int g;
		g = with_gap ? gap_len() : 0;
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
		row_coord_d0 <= rc[0]; row_coord_d1 <= rc[1]; row_coord_d2 <= rc[2];
		col_coord_d0 <= cc[0]; col_coord_d1 <= cc[1]; col_coord_d2 <= cc[2];
		row_treated <= rt; col_treated <= ct;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_pair(rc, cc, rt, ct);
		@(negedge clk);
	endtask

	task automatic send_random(int count, bit local_pair);
		logic signed [23:0] rc [3], cc [3];
		int mode;
		for (int k = 0; k < count; k++) begin
			mode = $urandom_range(5);
			for (int d = 0; d < 3; d++) begin
				rc[d] = rand_coord(mode);
				cc[d] = local_pair ? 24'(rc[d] + ($urandom_range(65536) - 32768))
					: rand_coord(mode);
			end
			send_pair(rc, cc, 1'($urandom), 1'($urandom), $urandom_range(3) != 0);
		end
	endtask

	task automatic drain();
		int w = 0;
		in_valid <= 0;
		while (sb.pending.size() != 0 && w < 100000) begin
			@(posedge clk);
			w++;
		end
		repeat (20) @(negedge clk);
	endtask

	task automatic write_cfg(logic [2:0] idx, logic [23:0] v);
		@(negedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
		@(posedge clk);
		sb.write_reg(idx, v);
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic load_setting(logic [23:0] wm, logic [23:0] wt, logic [23:0] lm,
			logic [23:0] lt, bit rnd);
		write_cfg(REG_WM0, rnd ? 24'($urandom_range(wm)) : wm);
		write_cfg(REG_WM1, rnd ? 24'($urandom_range(wm)) : wm);
		write_cfg(REG_WM2, rnd ? 24'($urandom_range(wm)) : wm);
		write_cfg(REG_WT0, rnd ? 24'($urandom_range(wt)) : wt);
		write_cfg(REG_WT1, rnd ? 24'($urandom_range(wt)) : wt);
		write_cfg(REG_WT2, rnd ? 24'($urandom_range(wt)) : wt);
		write_cfg(REG_LM, lm);
		write_cfg(REG_LT, lt);
	endtask

	// receiver with random stalls
	initial begin
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(200) == 0) begin
				out_ready <= 0;
				repeat ($urandom_range(40, 10)) @(negedge clk);
			end else begin
				out_ready <= ($urandom_range(9) < 7) || ($urandom_range(50) == 0);
			end
		end
	end

	always @(posedge clk)
		if (out_valid && out_ready)
			sb.check_entry(kernel_total, kernel_main, kernel_treat);

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic signed [23:0] a [3], b [3];
		sb = new();
		sb.reset_regs();
		arst_n = 0; cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
		in_valid = 0; row_treated = 0; col_treated = 0;
		row_coord_d0 = 0; row_coord_d1 = 0; row_coord_d2 = 0;
		col_coord_d0 = 0; col_coord_d1 = 0; col_coord_d2 = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: identical points, extremes, treatment combos
		a = '{0, 0, 0}; b = '{0, 0, 0};
		for (int t = 0; t < 4; t++) send_pair(a, b, t[0], t[1], 0);
		a = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF};
		b = '{24'sh800000, 24'sh800000, 24'sh800000};
		send_pair(a, b, 1, 1, 0);
		send_pair(b, a, 1, 0, 0);
		a = '{65536, 0, 0}; b = '{0, 65536, 24'shFF0000};
		send_pair(a, b, 1, 1, 0);
		drain();
		// large lambdas: saturation and total overflow
		load_setting(0, 0, 24'sh7FFFFF, 24'sh7FFFFF, 0);
		a = '{0, 0, 0};
		send_pair(a, a, 1, 1, 0);
		send_pair(a, a, 0, 1, 0);
		drain();
		load_setting(24'hFFFFFF, 24'hFFFFFF, 24'sh0C0000, 24'sh0BFFFF, 0);
		send_pair(a, a, 1, 1, 0);
		b = '{24'sh000100, 0, 0};
		send_pair(a, b, 1, 1, 0);
		drain();
		load_setting(65536, 65536, 24'sh800000, 24'shF40000, 0);
		send_pair(a, a, 1, 1, 0);
		drain();
		// exp near the edges
		load_setting(65536, 65536, 24'sh0B8000, 24'shF48000, 0);
		send_pair(a, a, 1, 1, 0);
		b = '{24'sh008000, 24'sh000100, 24'sh000001};
		send_pair(a, b, 1, 1, 0);
		drain();

		// random phases across several settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: load_setting(24'h01FFFF, 24'h01FFFF, 24'($urandom_range(0, 24'h060000)),
					24'($urandom_range(0, 24'h060000) - 24'h030000), 1);
				1: load_setting(24'hFFFFFF, 24'hFFFFFF, 24'($urandom), 24'($urandom), 1);
				2: load_setting(24'h000FFF, 24'h00FFFF, 24'h0A0000, 24'hFA0000, 1);
				default: load_setting(24'h00FFFF, 24'h03FFFF, 24'($urandom),
					24'($urandom), 1);
			endcase
			send_random(150, 1);
			send_random(55, 0);
			drain();
		end
		drain();
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
